// ===== src/gcm_pkg.sv =====
// Package for the greedy contact matcher: sizes, point and tag types,
// sequencer states and register codes. No dependencies.
package gcm_pkg;

  localparam int MAX_PREV   = 16;
  localparam int MAX_CURR   = 16;
  localparam int PREV_IDX_W = (MAX_PREV > 1) ? $clog2(MAX_PREV) : 1;
  localparam int CUR_IDX_W  = (MAX_CURR > 1) ? $clog2(MAX_CURR) : 1;
  localparam int PREV_CNT_W = $clog2(MAX_PREV + 1);
  localparam int CUR_CNT_W  = $clog2(MAX_CURR + 1);

  localparam int COORD_W = 20;
  localparam int SLOT_W  = 16;
  localparam int IMP_W   = 32;
  localparam int DIST_W  = 21;
  localparam int MAG_W   = 21;
  localparam int SQ_W    = 42;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic OP_PREV = 1'b0;
  localparam logic OP_CUR  = 1'b1;

  // register index as decoded from paddr[2]
  localparam logic REG_MAX_DIST = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic [IMP_W-1:0]  impulse;
    logic [SLOT_W-1:0] slot;
  } tag_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_LIM,
    S_LIMW,
    S_SCAN,
    S_COMMIT,
    S_EMIT
  } state_e;

endpackage

// ===== src/gcm_if.sv =====
// Channel interfaces for the greedy contact matcher (input load, result).
// Depends on gcm_pkg.
interface gcm_in_if;
  import gcm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic [SLOT_W-1:0]         slot_index;
  logic [IMP_W-1:0]          impulse_word;
  logic                      final_item;

  modport source (output valid, opcode, coord_x, coord_y, coord_z, slot_index,
                  impulse_word, final_item, input ready);
  modport sink (input valid, opcode, coord_x, coord_y, coord_z, slot_index,
                impulse_word, final_item, output ready);
endinterface

interface gcm_out_if;
  import gcm_pkg::*;
  logic              valid;
  logic              ready;
  logic              matched;
  logic [SLOT_W-1:0] prev_slot;
  logic [IMP_W-1:0]  carried_impulse;
  logic              overflow;
  logic              last_result;

  modport source (output valid, matched, prev_slot, carried_impulse, overflow,
                  last_result, input ready);
  modport sink (input valid, matched, prev_slot, carried_impulse, overflow,
                last_result, output ready);
endinterface

// ===== src/gcm_sq_unit.sv =====
// Shared squarer of the matcher: one 21-bit magnitude squared per cycle,
// result registered. Depends on gcm_pkg.
module gcm_sq_unit (
  input  logic                       clk_i,
  input  logic [gcm_pkg::MAG_W-1:0]  op_i,
  output logic [gcm_pkg::SQ_W-1:0]   sq_o
);
  import gcm_pkg::*;

  logic [SQ_W-1:0] sq_d, sq_q;

  assign sq_d = SQ_W'(op_i) * SQ_W'(op_i);

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o = sq_q;
endmodule

// ===== src/greedy_contact_matcher.sv =====
// Top level of the greedy contact matcher: stores, sequencer, APB register.
// Depends on gcm_pkg, gcm_if (gcm_in_if, gcm_out_if) and gcm_sq_unit.
//
//  channel | dir | handshake      | carries
//  in_i    | in  | valid/ready    | opcode, point, slot, impulse, final mark
//  out_o   | out | valid/ready    | match flag, slot, impulse, overflow, last
//  apb     | in  | psel/penable   | max_match_dist at byte address 0
//
// After the final item the threshold is squared (S_LIM, S_LIMW); if there are
// previous points, rounds of S_SCAN over all C*P pairs (C current, P previous
// points; x, y, z squared in turn by the shared squarer) and S_COMMIT run,
// up to min(C,P)+1 rounds; S_EMIT sends the results. in_i.ready is low from
// the final item until the last result is registered; out_o stalls hold the
// sequencer. Reset clears counts, flags and the register, not the stores.
module greedy_contact_matcher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gcm_in_if.sink                        in_i,
  gcm_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gcm_pkg::PADDR_W-1:0]   paddr,
  input  logic [gcm_pkg::PDATA_W-1:0]   pwdata,
  output logic [gcm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import gcm_pkg::*;

  state_e state_q, state_d;

  logic [DIST_W-1:0]     max_dist_q;
  point_t                prev_pts_q [MAX_PREV];
  tag_t                  prev_tag_q [MAX_PREV];
  point_t                cur_pts_q  [MAX_CURR];
  logic [PREV_IDX_W-1:0] cur_slot_q [MAX_CURR];
  logic [PREV_CNT_W-1:0] prev_cnt_q, prev_cnt_d;
  logic [CUR_CNT_W-1:0]  cur_cnt_q, cur_cnt_d;
  logic [MAX_PREV-1:0]   prev_used_q, prev_used_d;
  logic [MAX_CURR-1:0]   cur_done_q, cur_done_d;
  logic                  dropped_q, dropped_d;

  logic [CUR_IDX_W-1:0]  ci_q, ci_d;
  logic [PREV_IDX_W-1:0] pj_q, pj_d;
  logic [1:0]            step_q, step_d;
  logic [SQ_W-1:0]       lim_q, lim_d, acc_q, acc_d, best_q, best_d;
  logic                  found_q, found_d;
  logic [CUR_IDX_W-1:0]  bi_q, bi_d;
  logic [PREV_IDX_W-1:0] bj_q, bj_d;

  logic                  o_valid_q, o_valid_d;
  logic                  o_match_q, o_match_d;
  logic [SLOT_W-1:0]     o_slot_q, o_slot_d;
  logic [IMP_W-1:0]      o_imp_q, o_imp_d;
  logic                  o_ovf_q, o_ovf_d;
  logic                  o_last_q, o_last_d;

  logic in_acc, cfg_wr, out_free;
  logic prev_wr, cur_wr, slot_wr;
  logic last_ci, last_pj;
  logic [COORD_W-1:0] ax_a, ax_b;
  logic signed [COORD_W:0] diff;
  logic [MAG_W-1:0] mag, sq_op;
  logic [SQ_W-1:0] sq, pair_dist;
  logic eligible;
  tag_t emit_tag;

  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_MAX_DIST);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_MAX_DIST) ? PDATA_W'(max_dist_q) : '0;
  assign out_free = !o_valid_q || out_o.ready;

  assign last_ci = (CUR_CNT_W'(ci_q) + CUR_CNT_W'(1)) == cur_cnt_q;
  assign last_pj = (PREV_CNT_W'(pj_q) + PREV_CNT_W'(1)) == prev_cnt_q;

  // axis operands for the pair (ci, pj)
  always_comb begin
    case (step_q)
      2'd0:    begin ax_a = cur_pts_q[ci_q].x; ax_b = prev_pts_q[pj_q].x; end
      2'd1:    begin ax_a = cur_pts_q[ci_q].y; ax_b = prev_pts_q[pj_q].y; end
      2'd2:    begin ax_a = cur_pts_q[ci_q].z; ax_b = prev_pts_q[pj_q].z; end
      default: begin ax_a = '0; ax_b = '0; end
    endcase
  end

  assign diff  = $signed({ax_a[COORD_W-1], ax_a}) - $signed({ax_b[COORD_W-1], ax_b});
  assign mag   = diff[COORD_W] ? MAG_W'(-diff) : MAG_W'(diff);
  assign sq_op = (state_q == S_LIM) ? MAG_W'(max_dist_q) : mag;

  gcm_sq_unit u_sq (
    .clk_i (clk_i),
    .op_i  (sq_op),
    .sq_o  (sq)
  );

  assign pair_dist = acc_q + sq;
  assign eligible  = !cur_done_q[ci_q] && !prev_used_q[pj_q] && (pair_dist <= lim_q);
  assign emit_tag  = prev_tag_q[cur_slot_q[ci_q]];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:   if (in_acc && in_i.opcode == OP_CUR && in_i.final_item) state_d = S_LIM;
      S_LIM:    state_d = S_LIMW;
      S_LIMW:   state_d = (prev_cnt_q == '0) ? S_EMIT : S_SCAN;
      S_SCAN:   if (step_q == 2'd3 && last_ci && last_pj) state_d = S_COMMIT;
      S_COMMIT: state_d = found_q ? S_SCAN : S_EMIT;
      S_EMIT:   if (out_free && last_ci) state_d = S_LOAD;
      default:  state_d = S_LOAD;
    endcase
  end

  // datapath and control updates
  always_comb begin
    prev_cnt_d  = prev_cnt_q;
    cur_cnt_d   = cur_cnt_q;
    prev_used_d = prev_used_q;
    cur_done_d  = cur_done_q;
    dropped_d   = dropped_q;
    ci_d        = ci_q;
    pj_d        = pj_q;
    step_d      = step_q;
    lim_d       = lim_q;
    acc_d       = acc_q;
    best_d      = best_q;
    found_d     = found_q;
    bi_d        = bi_q;
    bj_d        = bj_q;
    o_valid_d   = o_valid_q && !out_o.ready;
    o_match_d   = o_match_q;
    o_slot_d    = o_slot_q;
    o_imp_d     = o_imp_q;
    o_ovf_d     = o_ovf_q;
    o_last_d    = o_last_q;
    prev_wr     = 1'b0;
    cur_wr      = 1'b0;
    slot_wr     = 1'b0;
    in_i.ready  = (state_q == S_LOAD);
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (in_i.opcode == OP_PREV) begin
            if (prev_cnt_q < PREV_CNT_W'(MAX_PREV)) begin
              prev_wr    = 1'b1;
              prev_cnt_d = prev_cnt_q + PREV_CNT_W'(1);
            end else begin
              dropped_d = 1'b1;
            end
          end else begin
            if (cur_cnt_q < CUR_CNT_W'(MAX_CURR)) begin
              cur_wr    = 1'b1;
              cur_cnt_d = cur_cnt_q + CUR_CNT_W'(1);
            end else begin
              dropped_d = 1'b1;
            end
          end
        end
        ci_d    = '0;
        pj_d    = '0;
        step_d  = '0;
        found_d = 1'b0;
      end
      S_LIMW: begin
        lim_d = sq;
      end
      S_SCAN: begin
        step_d = step_q + 2'd1;
        case (step_q)
          2'd0:    acc_d = '0;
          2'd1:    acc_d = sq;
          2'd2:    acc_d = acc_q + sq;
          default: begin
            // strict less-than keeps the first pair in scan order on ties
            if (eligible && (!found_q || pair_dist < best_q)) begin
              found_d = 1'b1;
              best_d  = pair_dist;
              bi_d    = ci_q;
              bj_d    = pj_q;
            end
            if (last_pj) begin
              pj_d = '0;
              ci_d = last_ci ? '0 : ci_q + CUR_IDX_W'(1);
            end else begin
              pj_d = pj_q + PREV_IDX_W'(1);
            end
          end
        endcase
      end
      S_COMMIT: begin
        if (found_q) begin
          cur_done_d[bi_q]  = 1'b1;
          prev_used_d[bj_q] = 1'b1;
          slot_wr           = 1'b1;
        end
        found_d = 1'b0;
        ci_d    = '0;
        pj_d    = '0;
        step_d  = '0;
      end
      S_EMIT: begin
        if (out_free) begin
          o_valid_d = 1'b1;
          o_match_d = cur_done_q[ci_q];
          o_slot_d  = cur_done_q[ci_q] ? emit_tag.slot : '0;
          o_imp_d   = cur_done_q[ci_q] ? emit_tag.impulse : '0;
          o_ovf_d   = dropped_q;
          o_last_d  = last_ci;
          if (last_ci) begin
            prev_cnt_d  = '0;
            cur_cnt_d   = '0;
            prev_used_d = '0;
            cur_done_d  = '0;
            dropped_d   = 1'b0;
            ci_d        = '0;
          end else begin
            ci_d = ci_q + CUR_IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      max_dist_q  <= '0;
      prev_cnt_q  <= '0;
      cur_cnt_q   <= '0;
      prev_used_q <= '0;
      cur_done_q  <= '0;
      dropped_q   <= 1'b0;
      found_q     <= 1'b0;
      step_q      <= '0;
      ci_q        <= '0;
      pj_q        <= '0;
      o_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_wr) max_dist_q <= pwdata[DIST_W-1:0];
      prev_cnt_q  <= prev_cnt_d;
      cur_cnt_q   <= cur_cnt_d;
      prev_used_q <= prev_used_d;
      cur_done_q  <= cur_done_d;
      dropped_q   <= dropped_d;
      found_q     <= found_d;
      step_q      <= step_d;
      ci_q        <= ci_d;
      pj_q        <= pj_d;
      o_valid_q   <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q    <= lim_d;
    acc_q    <= acc_d;
    best_q   <= best_d;
    bi_q     <= bi_d;
    bj_q     <= bj_d;
    o_match_q <= o_match_d;
    o_slot_q <= o_slot_d;
    o_imp_q  <= o_imp_d;
    o_ovf_q  <= o_ovf_d;
    o_last_q <= o_last_d;
    if (prev_wr) begin
      prev_pts_q[prev_cnt_q[PREV_IDX_W-1:0]] <= '{z: in_i.coord_z, y: in_i.coord_y,
                                                   x: in_i.coord_x};
      prev_tag_q[prev_cnt_q[PREV_IDX_W-1:0]] <= '{impulse: in_i.impulse_word,
                                                   slot: in_i.slot_index};
    end
    if (cur_wr) begin
      cur_pts_q[cur_cnt_q[CUR_IDX_W-1:0]] <= '{z: in_i.coord_z, y: in_i.coord_y,
                                                x: in_i.coord_x};
    end
    if (slot_wr) cur_slot_q[bi_q] <= bj_q;
  end

  assign out_o.valid           = o_valid_q;
  assign out_o.matched         = o_match_q;
  assign out_o.prev_slot       = o_slot_q;
  assign out_o.carried_impulse = o_imp_q;
  assign out_o.overflow        = o_ovf_q;
  assign out_o.last_result     = o_last_q;
endmodule

// ===== src/gcm_checker.sv =====
// Port-level checks for the greedy contact matcher, bound to the top level.
// Depends on gcm_pkg and greedy_contact_matcher.
module gcm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_opcode,
  input logic                        in_final,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_matched,
  input logic [gcm_pkg::SLOT_W-1:0]  out_slot,
  input logic [gcm_pkg::IMP_W-1:0]   out_imp,
  input logic                        out_last
);
  import gcm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_opcode == OP_CUR && in_final |=> !in_ready)
    else $error("load accepted right after final item");

  a_no_load_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_last |-> !in_ready)
    else $error("loads open before last result");

  a_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_matched |-> out_slot == '0 && out_imp == '0)
    else $error("unmatched result carries data");
endmodule

bind greedy_contact_matcher gcm_checker u_gcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .in_opcode   (in_i.opcode),
  .in_final    (in_i.final_item),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_matched (out_o.matched),
  .out_slot    (out_o.prev_slot),
  .out_imp     (out_o.carried_impulse),
  .out_last    (out_o.last_result)
);
